// ===== hw/rtl/vspe_pkg.sv =====
// ----------------------------------------------------------------------------
// vspe_pkg
// Shared types and constants for the vertex set permutation equivalence block.
// ----------------------------------------------------------------------------
package vspe_pkg;

    // field widths fixed by the transaction format
    localparam int SET_W       = 64;
    localparam int MAP_IDX_W   = 8;
    localparam int VTX_W       = 6;
    localparam int VCOUNT_W    = 7;
    localparam int MCOUNT_W    = 9;
    localparam int CFG_DATA_W  = 9;
    localparam int CFG_IDX_W   = 1;

    // item kinds
    localparam logic KIND_LOAD    = 1'b0;
    localparam logic KIND_COMPARE = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_COUNT    = 1'b1;

    // configuration reset values
    localparam logic [VCOUNT_W-1:0] VERTEX_COUNT_RST = 7'd64;
    localparam logic [MCOUNT_W-1:0] MAP_COUNT_RST    = 9'd0;

    // input transaction
    typedef struct packed {
        logic                 kind;
        logic [MAP_IDX_W-1:0] map_index;
        logic [VTX_W-1:0]     vertex_index;
        logic [VTX_W-1:0]     vertex_image;
        logic [SET_W-1:0]     set_one;
        logic [SET_W-1:0]     set_two;
    } t_in_item;

    // result transaction
    typedef struct packed {
        logic                 equivalent;
        logic                 by_map;
        logic [MAP_IDX_W-1:0] matching_map;
    } t_out_item;

    // control for the image unit, aligned with the table read data
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        logic sel;
    } t_img_ctl;

endpackage

// ===== hw/rtl/vspe_ram.sv =====
// ----------------------------------------------------------------------------
// vspe_ram
// Generic simple dual port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module vspe_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/vspe_image_unit.sv =====
// ----------------------------------------------------------------------------
// vspe_image_unit
// Builds the set image of one mask under one map, one vertex per cycle, and
// compares the finished image with the target mask.
// ----------------------------------------------------------------------------
module vspe_image_unit (
    input  logic                      i_clk,
    input  vspe_pkg::t_img_ctl        i_ctl,
    input  logic [vspe_pkg::VTX_W-1:0] i_image,
    input  logic [vspe_pkg::SET_W-1:0] i_target,
    output logic                      o_match
);
    import vspe_pkg::*;

    logic [SET_W-1:0] r_img;
    logic [SET_W-1:0] n_img;
    logic [SET_W-1:0] img_bit;

    // one-hot of the image vertex, only when the source vertex is present
    always_comb begin
        img_bit = '0;
        if (i_ctl.sel) begin
            img_bit[i_image] = 1'b1;
        end
        n_img = (i_ctl.first ? '0 : r_img) | img_bit;
    end

    // accumulator
    always_ff @(posedge i_clk) begin
        if (i_ctl.valid) begin
            r_img <= n_img;
        end
    end

    // image complete on the last vertex of a map
    assign o_match = i_ctl.valid && i_ctl.last && (n_img == i_target);

endmodule

// ===== hw/rtl/vertex_set_permutation_equivalence_top.sv =====
// ----------------------------------------------------------------------------
// vertex_set_permutation_equivalence_top
// Decides whether two vertex masks are equivalent under a stored map table.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_item) takes load and compare
//   transactions; a transaction is taken when valid is high and stall is low.
//   A load writes one map table entry and leaves the input free for the next;
//   it gives no result. A compare gives exactly one result on the output channel
//   (o_out_valid / i_out_stall / o_out_item).
//   A compare is accepted, then the population count runs over all MAX_VERTICES
//   vertex positions; when the counts agree but the masks differ, the table is
//   read once per vertex in use for each map tried (n * maps), through the
//   registered read port, and the result is then handed over. The single table
//   read port bounds how fast compares are worked through.
//   o_in_stall stays high while a compare is being worked on.
//   The result sits in an output register; if the receiver stalls, the block
//   returns to idle and takes further loads, and the next compare waits at its
//   end until the output register is free.
//   Configuration writes (i_cfg_we / i_cfg_idx / i_cfg_data) take effect at
//   once and must only be issued while the block is idle.
//   Synchronous reset clears the sequencer, the output valid and sets the
//   registers to vertex_count 64, map_count 0. The map table is not cleared.
// ----------------------------------------------------------------------------
module vertex_set_permutation_equivalence_top #(
    parameter int MAX_VERTICES = 64,
    parameter int MAX_MAPS     = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  vspe_pkg::t_in_item                i_in_item,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output vspe_pkg::t_out_item               o_out_item,
    input  logic                              i_cfg_we,
    input  logic [vspe_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [vspe_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import vspe_pkg::*;

    localparam int VW    = $clog2(MAX_VERTICES);
    localparam int MCW   = $clog2(MAX_MAPS + 1);
    localparam int DEPTH = MAX_MAPS * MAX_VERTICES;
    localparam int AW    = $clog2(DEPTH);
    localparam int DW    = VW + 2;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_COUNT = 4'b0010,
        S_SCAN  = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state r_state;

    logic [VCOUNT_W-1:0]     r_vertex_count;
    logic [MCOUNT_W-1:0]     r_map_count;

    logic [SET_W-1:0]        r_a;
    logic [MAX_VERTICES-1:0] r_b;
    logic [VW-1:0]           r_vlast;
    logic [MCW-1:0]          r_maps;
    logic [VW-1:0]           r_cv;
    logic [DW-1:0]           r_diff;
    logic [DW-1:0]           n_diff;

    logic                    r_issue;
    logic [VW-1:0]           r_iv;
    logic [MCW-1:0]          r_im;
    logic [AW-1:0]           r_base;

    t_img_ctl                r_p_ctl;
    logic [MCW-1:0]          r_p_map;

    t_out_item               r_res;
    t_out_item               r_out_item;
    logic                    r_out_valid;

    logic                    in_take;
    logic [VCOUNT_W-1:0]     n_sat;
    logic [SET_W-1:0]        in_mask;
    logic [MCW-1:0]          maps_sat;
    logic                    load_ok;
    logic                    ram_we;
    logic [AW-1:0]           ram_waddr;
    logic [AW-1:0]           ram_raddr;
    logic [VTX_W-1:0]        ram_rdata;
    logic [MAX_VERTICES-1:0] a_low;
    logic                    match;
    logic                    out_free;
    logic [31:0]             map_ext;

    assign in_take    = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vertex_count <= VERTEX_COUNT_RST;
            r_map_count    <= MAP_COUNT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_VERTEX_COUNT: r_vertex_count <= i_cfg_data[VCOUNT_W-1:0];
                CFG_MAP_COUNT:    r_map_count    <= i_cfg_data[MCOUNT_W-1:0];
                default:          ;
            endcase
        end
    end

    // saturated counts and vertex mask
    always_comb begin
        n_sat = (32'(r_vertex_count) > MAX_VERTICES) ? VCOUNT_W'(MAX_VERTICES)
                                                     : r_vertex_count;
        maps_sat = (32'(r_map_count) > MAX_MAPS) ? MCW'(MAX_MAPS)
                                                 : MCW'(r_map_count);
        for (int v = 0; v < SET_W; v++) begin
            in_mask[v] = (32'(v) < 32'(n_sat));
        end
    end

    // table write from load transactions
    assign load_ok   = (32'(i_in_item.map_index) < MAX_MAPS) &&
                       (32'(i_in_item.vertex_index) < MAX_VERTICES);
    assign ram_we    = in_take && (i_in_item.kind == KIND_LOAD) && load_ok;
    assign ram_waddr = AW'(32'(i_in_item.map_index) * MAX_VERTICES +
                           32'(i_in_item.vertex_index));
    assign ram_raddr = r_base + AW'(r_iv);

    vspe_ram #(
        .WIDTH (VTX_W),
        .DEPTH (DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_in_item.vertex_image),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    vspe_image_unit u_image (
        .i_clk    (i_clk),
        .i_ctl    (r_p_ctl),
        .i_image  (ram_rdata),
        .i_target (r_a),
        .o_match  (match)
    );

    // population count difference, one vertex per cycle
    assign a_low  = r_a[MAX_VERTICES-1:0];
    assign n_diff = r_diff + DW'(a_low[r_cv]) - DW'(r_b[r_cv]);
    assign map_ext = 32'(r_p_map);

    // operands captured at accept
    always_ff @(posedge i_clk) begin
        if (in_take && (i_in_item.kind == KIND_COMPARE)) begin
            r_a     <= i_in_item.set_one & in_mask;
            r_b     <= i_in_item.set_two[MAX_VERTICES-1:0] & in_mask[MAX_VERTICES-1:0];
            r_vlast <= VW'(n_sat - VCOUNT_W'(1));
            r_maps  <= maps_sat;
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_issue <= 1'b0;
            r_p_ctl <= '0;
        end else begin
            // read pipeline stage, aligned with the table read data
            r_p_ctl.valid <= r_issue && (r_state == S_SCAN);
            r_p_ctl.first <= (r_iv == '0);
            r_p_ctl.last  <= (r_iv == r_vlast);
            r_p_ctl.sel   <= r_b[r_iv];
            r_p_map       <= r_im;

            case (r_state)
                S_IDLE: begin
                    if (in_take && (i_in_item.kind == KIND_COMPARE)) begin
                        r_cv    <= '0;
                        r_diff  <= '0;
                        r_state <= S_COUNT;
                    end
                end
                S_COUNT: begin
                    r_diff <= n_diff;
                    r_cv   <= r_cv + VW'(1);
                    if (32'(r_cv) == MAX_VERTICES - 1) begin
                        if (n_diff != '0) begin
                            r_res   <= '0;
                            r_state <= S_DONE;
                        end else if (r_a[MAX_VERTICES-1:0] == r_b) begin
                            r_res   <= '{equivalent: 1'b1, by_map: 1'b0,
                                         matching_map: MAP_IDX_W'(0)};
                            r_state <= S_DONE;
                        end else if (r_maps == '0) begin
                            r_res   <= '0;
                            r_state <= S_DONE;
                        end else begin
                            r_res   <= '0;
                            r_iv    <= '0;
                            r_im    <= '0;
                            r_base  <= '0;
                            r_issue <= 1'b1;
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    // map finished in the image unit
                    if (match) begin
                        r_res   <= '{equivalent: 1'b1, by_map: 1'b1,
                                     matching_map: map_ext[MAP_IDX_W-1:0]};
                        r_issue <= 1'b0;
                        r_state <= S_DONE;
                    end else if (r_p_ctl.valid && r_p_ctl.last &&
                                 (r_p_map == r_maps - MCW'(1))) begin
                        r_issue <= 1'b0;
                        r_state <= S_DONE;
                    end else if (r_issue) begin
                        // issue one table read per cycle
                        if (r_iv == r_vlast) begin
                            r_iv   <= '0;
                            r_base <= r_base + AW'(MAX_VERTICES);
                            r_im   <= r_im + MCW'(1);
                            if (r_im == r_maps - MCW'(1)) begin
                                r_issue <= 1'b0;
                            end
                        end else begin
                            r_iv <= r_iv + VW'(1);
                        end
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_DONE) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && out_free) begin
            r_out_item <= r_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ===== hw/rtl/vspe_checker.sv =====
// ----------------------------------------------------------------------------
// vspe_checker
// Port level checks for the vertex set permutation equivalence block.
// ----------------------------------------------------------------------------
module vspe_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                o_in_stall,
    input  vspe_pkg::t_in_item  i_in_item,
    input  logic                o_out_valid,
    input  logic                i_out_stall,
    input  vspe_pkg::t_out_item o_out_item
);
    import vspe_pkg::*;

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_item)))
        else $error("result changed while stalled");

    // a map hit is always an equivalence
    a_map_equiv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.by_map) |-> o_out_item.equivalent)
        else $error("by_map without equivalent");

    // map index only reported for a map hit
    a_map_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_item.by_map) |-> (o_out_item.matching_map == '0))
        else $error("matching_map set without map hit");

    // a compare transaction keeps the input busy on the next cycle
    a_cmp_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_in_item.kind == KIND_COMPARE)) |=> o_in_stall)
        else $error("compare accepted but input not busy");

    // reset leaves no result pending
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind vertex_set_permutation_equivalence_top vspe_checker u_vspe_checker (.*);

// ===== test/tb_vertex_set_permutation_equivalence_top.sv =====
// ----------------------------------------------------------------------------
// tb_vertex_set_permutation_equivalence_top
// Self-checking bench for the vertex set equivalence block. The first few maps
// are preloaded with random permutations over the first few vertices, and no
// compare ever depends on a table entry that has not been written. A short directed
// sequence and random load/compare traffic then run over several register
// settings. The sender idles in bursts, the receiver stalls on its own pattern
// and holds off once for a long stretch. Every verdict is checked against a
// behavioural predictor.
// ----------------------------------------------------------------------------
module tb_vertex_set_permutation_equivalence_top;
    timeunit 1ns;
    timeprecision 1ps;

    import vspe_pkg::*;

    localparam int N_VTX         = 64;
    localparam int N_MAPS        = 256;
    localparam int CLK_PERIOD    = 12;
    localparam int RESET_CYCLES  = 11;
    localparam int CYCLE_LIMIT   = 6_000_000;
    localparam int HOLD_CYCLES   = 3000;
    localparam int IDLE_GAP      = 8;
    localparam int END_CYCLES    = 200;
    localparam int RANDOM_PHASES = 3;
    localparam int PHASE_ITEMS   = 16;
    localparam int PRE_MAPS      = 4;
    localparam int PRE_VTX       = 8;
    localparam logic [SET_W-1:0] PRE_MASK = SET_W'((64'd1 << PRE_VTX) - 64'd1);

    // predictor of verdicts, with its own copy of the map table and registers
    class orbit_checker;
        logic [VTX_W-1:0]    image_of [N_MAPS][N_VTX];
        bit                  written [N_MAPS][N_VTX];
        logic [VCOUNT_W-1:0] vertex_count;
        logic [MCOUNT_W-1:0] map_count;
        t_out_item           pending_verdicts [$];
        int                  failures;

        function new();
            vertex_count = VERTEX_COUNT_RST;
            map_count    = MAP_COUNT_RST;
            failures     = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_VERTEX_COUNT) begin
                vertex_count = data[VCOUNT_W-1:0];
            end else begin
                map_count = data[MCOUNT_W-1:0];
            end
        endfunction

        function int live_vertices();
            return (vertex_count > N_VTX) ? N_VTX : int'(vertex_count);
        endfunction

        function int live_maps();
            return (map_count > N_MAPS) ? N_MAPS : int'(map_count);
        endfunction

        function logic [SET_W-1:0] live_mask();
            int n;
            n = live_vertices();
            return (n >= SET_W) ? {SET_W{1'b1}} : ((64'd1 << n) - 64'd1);
        endfunction

        // plain set image; colliding vertices merge into one bit
        function logic [SET_W-1:0] image_under_map(int m, logic [SET_W-1:0] s);
            logic [SET_W-1:0] img;
            img = '0;
            for (int v = 0; v < live_vertices(); v++) begin
                if (s[v]) img[image_of[m][v]] = 1'b1;
            end
            return img;
        endfunction

        // true when the map scan of this compare would depend on an unwritten entry
        function bit reads_unwritten(logic [SET_W-1:0] one, logic [SET_W-1:0] two);
            logic [SET_W-1:0] a;
            logic [SET_W-1:0] b;
            a = one & live_mask();
            b = two & live_mask();
            if ($countones(a) != $countones(b) || a == b) return 1'b0;
            for (int m = 0; m < live_maps(); m++) begin
                for (int v = 0; v < live_vertices(); v++) begin
                    if (b[v] && !written[m][v]) return 1'b1;
                end
                if (image_under_map(m, b) == a) return 1'b0;
            end
            return 1'b0;
        endfunction

        function t_out_item verdict_for(t_in_item it);
            t_out_item        verdict;
            logic [SET_W-1:0] a;
            logic [SET_W-1:0] b;
            verdict = '0;
            a = it.set_one & live_mask();
            b = it.set_two & live_mask();
            if ($countones(a) != $countones(b)) return verdict;
            if (a == b) begin
                verdict.equivalent = 1'b1;
                return verdict;
            end
            // first map carrying the second set onto the first wins
            for (int m = 0; m < live_maps(); m++) begin
                if (image_under_map(m, b) == a) begin
                    verdict.equivalent   = 1'b1;
                    verdict.by_map       = 1'b1;
                    verdict.matching_map = MAP_IDX_W'(m);
                    return verdict;
                end
            end
            return verdict;
        endfunction

        function void note_transaction(t_in_item it);
            if (it.kind == KIND_LOAD) begin
                image_of[it.map_index][it.vertex_index] = it.vertex_image;
                written[it.map_index][it.vertex_index]  = 1'b1;
            end else begin
                pending_verdicts.push_back(verdict_for(it));
            end
        endfunction

        function void check_verdict(t_out_item got);
            t_out_item want;
            if (pending_verdicts.size() == 0) begin
                $display("%0t: unexpected result, expected none, got eq %0b by_map %0b map %0d",
                         $time, got.equivalent, got.by_map, got.matching_map);
                failures++;
                return;
            end
            want = pending_verdicts.pop_front();
            if (got.equivalent !== want.equivalent) begin
                $display("%0t: equivalent expected %0b got %0b",
                         $time, want.equivalent, got.equivalent);
                failures++;
            end
            if (got.by_map !== want.by_map) begin
                $display("%0t: by_map expected %0b got %0b", $time, want.by_map, got.by_map);
                failures++;
            end
            if (got.matching_map !== want.matching_map) begin
                $display("%0t: matching_map expected %0d got %0d",
                         $time, want.matching_map, got.matching_map);
                failures++;
            end
        endfunction
    endclass

    // clock, reset and block inputs, all known from time zero
    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    t_in_item              in_item   = '0;
    logic                  out_stall = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx   = CFG_VERTEX_COUNT;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    logic      in_stall;
    logic      out_valid;
    t_out_item out_item;

    orbit_checker orbit;
    int           burst_left    = 0;
    bit           squeeze_armed = 1'b0;
    int           cycles        = 0;

    vertex_set_permutation_equivalence_top dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_item  (in_item),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_item (out_item),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // run limit
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb_vertex_set_permutation_equivalence_top: errors");
            $finish;
        end
    end

    // result transactions: sampled on the falling edge before the accepting edge
    always @(negedge clk) begin
        if (rst_n && out_valid === 1'b1 && !out_stall) begin
            orbit.check_verdict(out_item);
        end
    end

    // receiver stall pattern, with one long hold-off once armed
    initial begin : result_sink
        int run_left;
        bit run_stalls;
        run_left   = 0;
        run_stalls = 1'b0;
        forever begin
            @(posedge clk);
            if (squeeze_armed) begin
                squeeze_armed = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                if (run_left == 0) begin
                    run_stalls = ($urandom_range(0, 2) == 0);
                    run_left   = run_stalls ? $urandom_range(1, 6) : $urandom_range(1, 20);
                end
                run_left--;
                out_stall <= run_stalls;
            end
        end
    end

    function automatic logic [SET_W-1:0] random_vertices();
        return {$urandom, $urandom};
    endfunction

    // offer one transaction, idling between bursts, and wait until taken
    task automatic send_item(input t_in_item it);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_item  <= it;
        @(negedge clk);
        while (in_stall) @(negedge clk);
        @(posedge clk);
        orbit.note_transaction(it);
    endtask

    task automatic send_load(input int m, input int v, input int w);
        t_in_item it;
        it.kind         = KIND_LOAD;
        it.map_index    = MAP_IDX_W'(m);
        it.vertex_index = VTX_W'(v);
        it.vertex_image = VTX_W'(w);
        it.set_one      = random_vertices();
        it.set_two      = random_vertices();
        send_item(it);
    endtask

    // a compare whose scan would depend on unwritten entries becomes an identity
    task automatic send_compare(input logic [SET_W-1:0] one, input logic [SET_W-1:0] two);
        t_in_item it;
        if (orbit.reads_unwritten(one, two)) one = two;
        it.kind         = KIND_COMPARE;
        it.map_index    = MAP_IDX_W'($urandom_range(0, 255));
        it.vertex_index = VTX_W'($urandom_range(0, 63));
        it.vertex_image = VTX_W'($urandom_range(0, 63));
        it.set_one      = one;
        it.set_two      = two;
        send_item(it);
    endtask

    // write vertices 0..n-1 of map m as a random permutation of 0..n-1
    task automatic load_shuffle(input int m, input int n);
        int perm [N_VTX];
        int j;
        int t;
        for (int v = 0; v < n; v++) perm[v] = v;
        for (int v = n - 1; v > 0; v--) begin
            j       = $urandom_range(0, v);
            t       = perm[v];
            perm[v] = perm[j];
            perm[j] = t;
        end
        for (int v = 0; v < n; v++) send_load(m, v, perm[v]);
    endtask

    // wait until every verdict is in, then let loads still in flight settle
    task automatic drain(input int extra);
        in_valid <= 1'b0;
        burst_left = 0;
        while (orbit.pending_verdicts.size() != 0) @(posedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_settings(input logic [VCOUNT_W-1:0] vc, input logic [MCOUNT_W-1:0] mc);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_VERTEX_COUNT;
        cfg_data <= CFG_DATA_W'(vc);
        @(posedge clk);
        orbit.write_register(CFG_VERTEX_COUNT, CFG_DATA_W'(vc));
        cfg_idx  <= CFG_MAP_COUNT;
        cfg_data <= mc;
        @(posedge clk);
        orbit.write_register(CFG_MAP_COUNT, mc);
        cfg_we <= 1'b0;
    endtask

    initial begin : stimulus
        logic [SET_W-1:0]    b;
        logic [SET_W-1:0]    mask;
        logic [VCOUNT_W-1:0] vc;
        logic [MCOUNT_W-1:0] mc;
        int                  r;
        int                  n;
        int                  maps;
        int                  m_pick;

        orbit = new();
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // the first few maps written over the first few vertices
        for (int m = 0; m < PRE_MAPS; m++) load_shuffle(m, PRE_VTX);

        // no maps: identity, count mismatch, equal count without a match
        send_compare('0, '0);
        send_compare('1, '1);
        send_compare(64'h1, 64'h3);
        send_compare(64'h1, 64'h2);

        drain(IDLE_GAP);
        write_settings(7'd64, 9'd4);
        b = random_vertices() & PRE_MASK;
        send_compare(orbit.image_under_map(2, b), b);
        // map 1 folds vertices 0 and 1 onto vertex 5
        send_load(1, 0, 5);
        send_load(1, 1, 5);
        send_compare(64'h60, 64'h3);
        send_compare({b[62:0], b[63]}, b);

        // map 0 sends vertex 0 outside the vertices in use; upper bits masked off
        drain(IDLE_GAP);
        write_settings(7'd4, 9'd4);
        send_load(0, 0, 40);
        send_compare(64'hA5A5_0000_0000_0002, 64'h5A5A_0000_0000_0001);

        // no vertices in use: both sets empty
        drain(IDLE_GAP);
        write_settings(7'd0, 9'd4);
        send_compare(random_vertices(), random_vertices());

        // saturated counts: match within the written maps, then a count mismatch
        drain(IDLE_GAP);
        write_settings(7'd100, 9'd511);
        send_compare(orbit.image_under_map(PRE_MAPS - 1, b), b);
        send_compare(b ^ 64'h1, b);

        drain(IDLE_GAP);
        write_settings(7'd127, 9'd256);
        send_compare(orbit.image_under_map(1, b), b);

        // single vertex
        drain(IDLE_GAP);
        write_settings(7'd1, 9'd256);
        send_compare(64'h1, 64'h1);
        send_compare(64'h1, 64'h0);
        send_compare(64'hFFFF_FFFF_FFFF_FFFE, 64'h0);

        // random phases, one with a large map count
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            drain(IDLE_GAP);
            r  = $urandom_range(0, 9);
            vc = (r < 6)  ? VCOUNT_W'($urandom_range(1, PRE_VTX)) :
                 (r == 6) ? VCOUNT_W'($urandom_range(2, 64)) :
                 (r == 7) ? VCOUNT_W'(1) :
                 (r == 8) ? VCOUNT_W'(0) : VCOUNT_W'($urandom_range(65, 127));
            if (p == 0) begin
                mc = MCOUNT_W'($urandom_range(1, PRE_MAPS));
            end else if (p == 2) begin
                mc = MCOUNT_W'($urandom_range(256, 511));
            end else begin
                mc = ($urandom_range(0, 5) == 0) ? '0 : MCOUNT_W'($urandom_range(1, 16));
            end
            write_settings(vc, mc);
            n    = orbit.live_vertices();
            maps = orbit.live_maps();
            mask = orbit.live_mask();

            if (p == 0) squeeze_armed = 1'b1;

            for (int k = 0; k < PHASE_ITEMS; k++) begin
                r      = $urandom_range(0, 99);
                b      = random_vertices() & PRE_MASK;
                m_pick = (maps == 0) ? 0 :
                         $urandom_range(0, ((maps < PRE_MAPS) ? maps : PRE_MAPS) - 1);
                if (r < 20) begin
                    send_load(m_pick,
                              (n == 0) ? $urandom_range(0, 63) : $urandom_range(0, n - 1),
                              (n > 0 && $urandom_range(0, 9) < 7) ?
                                  $urandom_range(0, n - 1) : $urandom_range(0, 63));
                end else if (r < 55) begin
                    send_compare(orbit.image_under_map(m_pick, b) | (random_vertices() & ~mask), b);
                end else if (r < 65) begin
                    send_compare(b, b);
                end else if (r < 80) begin
                    send_compare({b[62:0], b[63]}, b);
                end else begin
                    send_compare(random_vertices(), b);
                end
            end
        end

        drain(END_CYCLES);
        if (orbit.failures == 0 && orbit.pending_verdicts.size() == 0) begin
            $display("tb_vertex_set_permutation_equivalence_top: clean");
        end else begin
            $display("tb_vertex_set_permutation_equivalence_top: errors");
        end
        $finish;
    end

endmodule
